// ===== rtl/mcrb_pkg.sv =====
package mcrb_pkg;

   localparam int REG_WORDS_DEF = 128;
   localparam int SEM_COUNT_DEF = 16;

   localparam int DATA_W  = 32;
   localparam int OFF_W   = 17;
   localparam int IDX_W   = OFF_W - 2;   // word index taken from the byte offset
   localparam int SEM_W   = 4;           // 4 KB slots in a 64 KB window
   localparam int NOISE_W = 4;

   localparam logic [OFF_W-1:0] OFF_EEPROM   = 17'h00034;
   localparam logic [OFF_W-1:0] OFF_REFRESH  = 17'h0004c;
   localparam logic [OFF_W-1:0] OFF_CPU_ERR  = 17'h000ec;
   localparam logic [OFF_W-1:0] OFF_GIO_ERR  = 17'h000fc;
   localparam logic [OFF_W-1:0] OFF_SYS_SEM  = 17'h00104;
   localparam logic [OFF_W-1:0] OFF_FREE_CTR = 17'h01004;
   localparam logic [OFF_W-1:0] OFF_DMA_STAT = 17'h0204c;

   localparam logic [DATA_W-1:0] EEPROM_MASK = 32'h0000001e;

   // reset words of the file
   localparam logic [IDX_W-1:0] IDX_MEMCFG0  = IDX_W'(32'hc4 / 4);
   localparam logic [IDX_W-1:0] IDX_MEMCFG1  = IDX_W'(32'hcc / 4);
   localparam logic [IDX_W-1:0] IDX_CPU_TIME = IDX_W'(32'hd4 / 4);
   localparam logic [IDX_W-1:0] IDX_GIO_TIME = IDX_W'(32'hdc / 4);

   localparam logic [DATA_W-1:0] RST_MEMCFG0  = 32'hFF20FF40;
   localparam logic [DATA_W-1:0] RST_MEMCFG1  = 32'hFF40FF80;
   localparam logic [DATA_W-1:0] RST_CPU_TIME = 32'h01454333;
   localparam logic [DATA_W-1:0] RST_GIO_TIME = 32'h00004333;

   typedef enum logic [2:0] {
      ACC_PLAIN,
      ACC_EEPROM,
      ACC_REFRESH,
      ACC_ERR,
      ACC_SYS_SEM,
      ACC_FREE_CTR,
      ACC_DMA,
      ACC_USER_SEM
   } access_kind_type;

   typedef struct packed {
      logic                 is_write;
      access_kind_type      kind;
      logic [SEM_W-1:0]     sem;
      logic [NOISE_W-1:0]   noise;
   } stage_type;

   function automatic access_kind_type decode_kind(input logic [OFF_W-1:0] off);
      access_kind_type k;
      k = ACC_PLAIN;
      priority if (off == OFF_EEPROM) begin
         k = ACC_EEPROM;
      end else if (off == OFF_REFRESH) begin
         k = ACC_REFRESH;
      end else if (off == OFF_CPU_ERR || off == OFF_GIO_ERR) begin
         k = ACC_ERR;
      end else if (off == OFF_SYS_SEM) begin
         k = ACC_SYS_SEM;
      end else if (off == OFF_FREE_CTR) begin
         k = ACC_FREE_CTR;
      end else if (off == OFF_DMA_STAT) begin
         k = ACC_DMA;
      end else if (off[OFF_W-1]) begin
         k = ACC_USER_SEM;
      end else begin
         k = ACC_PLAIN;
      end
      return k;
   endfunction

   function automatic logic [DATA_W-1:0] reset_word(input logic [IDX_W-1:0] idx);
      logic [DATA_W-1:0] w;
      unique case (idx)
         IDX_MEMCFG0:  w = RST_MEMCFG0;
         IDX_MEMCFG1:  w = RST_MEMCFG1;
         IDX_CPU_TIME: w = RST_CPU_TIME;
         IDX_GIO_TIME: w = RST_GIO_TIME;
         default:      w = '0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/mcrb_ram.sv =====
module mcrb_ram
   #(
      parameter int WIDTH = 32,
      parameter int DEPTH = 128
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mcrb_file.sv =====
module mcrb_file
   import mcrb_pkg::*;
   #(
      parameter int REG_WORDS = REG_WORDS_DEF
   )
   (
      input  logic              clock,
      input  logic              reset,
      input  logic              acc,
      input  logic              is_write,
      input  logic [IDX_W-1:0]  idx,
      input  logic [DATA_W-1:0] wr_data,
      output logic [DATA_W-1:0] rd_word
   );

   localparam int AW = $clog2(REG_WORDS);

   logic                 in_range;
   logic [AW-1:0]        addr;
   logic                 wr_en;
   logic [DATA_W-1:0]    ram_q;

   logic [REG_WORDS-1:0] valid_ff;
   logic                 hit_ff;
   logic                 in_range_ff;
   logic [DATA_W-1:0]    rst_val_ff;

   assign in_range = idx < IDX_W'(REG_WORDS);
   assign addr     = idx[AW-1:0];
   assign wr_en    = acc && is_write && in_range;

   mcrb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REG_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (acc),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   // unwritten words read back their reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         hit_ff      <= valid_ff[addr];
         in_range_ff <= in_range;
         rst_val_ff  <= reset_word(idx);
      end
   end

   assign rd_word = in_range_ff ? (hit_ff ? ram_q : rst_val_ff) : '0;

endmodule

// ===== rtl/mcrb_resp.sv =====
module mcrb_resp
   import mcrb_pkg::*;
   #(
      parameter int SEM_COUNT = SEM_COUNT_DEF
   )
   (
      input  logic              clock,
      input  logic              reset,
      input  logic              advance,
      input  stage_type         s1,
      input  logic [DATA_W-1:0] file_word,
      output logic [DATA_W-1:0] read_data
   );

   logic                       sys_sem_ff, sys_sem_in;
   logic [SEM_COUNT-1:0]       user_sem_ff, user_sem_in;
   logic [DATA_W-1:0]          refresh_ff, refresh_in;
   logic [DATA_W-1:0]          free_ff, free_in;
   logic [DATA_W-1:0]          read_data_ff, read_data_in;

   logic [SEM_COUNT-1:0]       sem_hit;
   logic                       sem_bit;

   always_comb begin
      for (int i = 0; i < SEM_COUNT; i++) begin
         sem_hit[i] = (s1.sem == SEM_W'(i));
      end
   end

   // no hit for numbers past the last semaphore
   assign sem_bit = |(sem_hit & user_sem_ff);

   always_comb begin
      sys_sem_in   = sys_sem_ff;
      user_sem_in  = user_sem_ff;
      refresh_in   = refresh_ff;
      free_in      = free_ff;
      read_data_in = '0;
      if (s1.is_write) begin
         if (s1.kind == ACC_SYS_SEM) begin
            sys_sem_in = 1'b0;
         end else if (s1.kind == ACC_USER_SEM) begin
            user_sem_in = user_sem_ff & ~sem_hit;
         end
      end else begin
         unique case (s1.kind)
            ACC_PLAIN, ACC_ERR: begin
               read_data_in = file_word;
            end
            ACC_EEPROM: begin
               read_data_in = (file_word ^ {{(DATA_W-NOISE_W-1){1'b0}}, s1.noise, 1'b0})
                              & EEPROM_MASK;
            end
            ACC_REFRESH: begin
               read_data_in = refresh_ff;
               refresh_in   = refresh_ff - DATA_W'(1);
            end
            ACC_SYS_SEM: begin
               read_data_in = {{(DATA_W-1){1'b0}}, sys_sem_ff};
               sys_sem_in   = 1'b1;
            end
            ACC_FREE_CTR: begin
               read_data_in = free_ff;
               free_in      = free_ff + DATA_W'(1);
            end
            ACC_DMA: begin
               read_data_in = '0;
            end
            ACC_USER_SEM: begin
               read_data_in = {{(DATA_W-1){1'b0}}, sem_bit};
               user_sem_in  = user_sem_ff | sem_hit;
            end
            default: begin
               read_data_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_sem_ff  <= 1'b0;
         user_sem_ff <= '0;
         refresh_ff  <= '0;
         free_ff     <= '0;
      end else if (advance) begin
         sys_sem_ff  <= sys_sem_in;
         user_sem_ff <= user_sem_in;
         refresh_ff  <= refresh_in;
         free_ff     <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         read_data_ff <= read_data_in;
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/memory_controller_register_block_unit.sv =====
// A request beat accepted into stage 1 moves on into the response register when stage 1
// advances, that is when the response register is empty or being drained.
// Throughput: one access per cycle unless stalled; stage 1 and the response register
// each hold one beat; the file RAM takes one write and one registered read per cycle.
// Reset (synchronous, active high) empties both stages, clears semaphores and counters
// and marks every file word unwritten, so the file reads its reset values at once.
module memory_controller_register_block_unit
   import mcrb_pkg::*;
   #(
      parameter int REG_WORDS = REG_WORDS_DEF,
      parameter int SEM_COUNT = SEM_COUNT_DEF
   )
   (
      input  logic                clock,
      input  logic                reset,

      input  logic                req_valid,
      output logic                req_ready,
      input  logic                req_cmd,
      input  logic [OFF_W-1:0]    req_byte_offset,
      input  logic [DATA_W-1:0]   req_write_data,
      input  logic [NOISE_W-1:0]  req_eeprom_noise,

      output logic                rsp_valid,
      input  logic                rsp_ready,
      output logic [DATA_W-1:0]   rsp_read_data
   );

   logic              req_acc;
   logic              s1_adv;
   logic              s1_valid_ff, s1_valid_in;
   logic              s2_valid_ff, s2_valid_in;
   stage_type         s1_ff, s1_in;
   access_kind_type   req_kind;
   logic [DATA_W-1:0] file_wdata;
   logic [DATA_W-1:0] file_word;

   // Handshake. Stage 1 holds the accepted beat while the file RAM read
   // completes; stage 2 is the response register. Stage 1 moves on whenever
   // the response register is empty or being drained.
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = s2_valid_ff;

   assign s1_valid_in = req_acc || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Offset decode is done once, on the way in.
   assign req_kind = decode_kind(req_byte_offset);

   assign s1_in.is_write = req_cmd;
   assign s1_in.kind     = req_kind;
   assign s1_in.sem      = req_byte_offset[OFF_W-2 -: SEM_W];
   assign s1_in.noise    = req_eeprom_noise;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= s1_in;
      end
   end

   // The file is written and read at acceptance. Writes to the error-status
   // words store zero. Beats touch the file in acceptance order, so the
   // next beat's read already sees this one's write.
   assign file_wdata = (req_kind == ACC_ERR) ? '0 : req_write_data;

   mcrb_file #(
      .REG_WORDS (REG_WORDS)
   ) u_file (
      .clock    (clock),
      .reset    (reset),
      .acc      (req_acc),
      .is_write (req_cmd),
      .idx      (req_byte_offset[OFF_W-1:2]),
      .wr_data  (file_wdata),
      .rd_word  (file_word)
   );

   // Semaphores and counters are updated as the beat leaves stage 1, in the
   // same step that forms the response word.
   mcrb_resp #(
      .SEM_COUNT (SEM_COUNT)
   ) u_resp (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_adv),
      .s1        (s1_ff),
      .file_word (file_word),
      .read_data (rsp_read_data)
   );

   // Both stages come up empty after reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // A write beat always answers with zero.
   a_write_zero : assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_ff.is_write |=> rsp_valid && rsp_read_data == '0)
      else $error("write beat returned nonzero data");

   // With both stages full and the response stalled, no new beat is taken.
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && !rsp_ready |-> !req_ready)
      else $error("beat accepted while both stages full");

   // A beat leaving stage 1 lands in the response register.
   a_advance_lands : assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid)
      else $error("advanced beat lost");

endmodule
